@@ design/sbnd_pkg.sv @@
`default_nettype none

package sbnd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int DLEN_W      = 4;
  localparam int COUNT_W     = 14;
  localparam int FIELD_W     = 13;
  localparam int OUT_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_BYTES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_LEN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_COUNT = 2'd2;

  localparam logic signed [COUNT_W-1:0] COUNT_LIMIT = 14'sd4097;

  typedef struct packed {
    logic              shift;
    logic [DLEN_W-1:0] len;
  } win_ctrl_t;

endpackage

`default_nettype wire

@@ design/substring_before_nth_delimiter.sv @@
// Substring before the nth delimiter.
// Slave stream: one text byte per transfer in s_tdata, s_tuser high when the
// byte is real, s_tlast on the final transfer of a value (s_tuser low with
// s_tlast adds no byte). Master stream: one result per value with
// slice start and length in m_tdata and the too-long flag in m_tuser.
// Config: cfg_we/cfg_index/cfg_data write delimiter bytes, delimiter length
// and the signed count; write only while no value is in flight.
// Throughput: one byte per cycle while a value streams in; the delimiter is
// matched in a row of byte cells as each byte shifts in, and the match map is
// kept in a bit memory with one write and one registered read port.
// After the last transfer the result is set up in an evaluate state for a
// positive or zero count; for a negative count a backward walk then reads one
// map entry per cycle, from the last delimiter position toward offset zero.
// s_tready drops from the last transfer until the result is loaded into the
// output register; bytes of the next value are taken while that result
// waits on m_tready. Reset (synchronous) clears state, config, counters, flags
// and valids but not the result or walk registers; the match map needs no clearing.
`default_nettype none

module substring_before_nth_delimiter #(
  parameter int MAX_VALUE_LEN = 4096,
  parameter int MAX_DELIM_LEN = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [7:0]                           s_tdata,  // value_byte
  input  wire logic                                 s_tuser,  // byte_present
  input  wire logic                                 s_tlast,  // last_byte
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // result_start [12:0], slice_length [25:13], zero [31:26]
  output logic [sbnd_pkg::OUT_DATA_W-1:0]           m_tdata,
  output logic                                      m_tuser,  // too_long
  input  wire logic                                 cfg_we,
  input  wire logic [sbnd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [sbnd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ADDR_W = $clog2(MAX_VALUE_LEN);
  localparam int CNT_W  = $clog2(MAX_VALUE_LEN + 1);
  localparam int CMP_W  = (CNT_W > sbnd_pkg::FIELD_W) ? CNT_W : sbnd_pkg::FIELD_W;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0]                          state;
  logic [63:0]                         delim_bytes;
  logic [sbnd_pkg::DLEN_W-1:0]         delim_len;
  logic signed [sbnd_pkg::COUNT_W-1:0] count;

  logic [CNT_W-1:0]  bytes_seen;
  logic [CNT_W-1:0]  fwd_hits;
  logic [CNT_W-1:0]  next_start;
  logic [ADDR_W-1:0] found_off;
  logic              found;
  logic              overflow;

  logic [CNT_W-1:0]  res_start;
  logic [CNT_W-1:0]  res_len;

  logic [ADDR_W-1:0] rd_addr;
  logic              rd_more;
  logic              rd_vld;
  logic [ADDR_W-1:0] rd_tag;
  logic              rd_bit;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  walk_hits;

  logic match_map [MAX_VALUE_LEN];

  sbnd_pkg::win_ctrl_t win_ctrl;
  logic                win_hit;

  logic                                in_fire;
  logic                                byte_take;
  logic [CNT_W-1:0]                    seen_inc;
  logic [CNT_W-1:0]                    len_ext;
  logic                                pos_ok;
  logic [ADDR_W-1:0]                   wr_off;
  logic                                fwd_take;
  logic [CNT_W-1:0]                    hits_inc;
  logic                                count_pos;
  logic                                count_zero;
  logic [sbnd_pkg::FIELD_W-1:0]        count_mag;
  logic                                found_now;
  logic [CNT_W-1:0]                    tag_end;
  logic [CNT_W-1:0]                    walk_inc;
  logic                                walk_take;
  logic signed [sbnd_pkg::COUNT_W-1:0] cfg_count;

  assign s_tready  = (state == ST_RUN);
  assign in_fire   = s_tvalid && s_tready;
  assign byte_take = in_fire && s_tuser && (bytes_seen < CNT_W'(MAX_VALUE_LEN));
  assign seen_inc  = bytes_seen + 1'b1;
  assign len_ext   = CNT_W'(delim_len);
  assign pos_ok    = (delim_len != '0) && (seen_inc >= len_ext);
  assign wr_off    = ADDR_W'(seen_inc - len_ext);
  assign fwd_take  = byte_take && pos_ok && win_hit && (CNT_W'(wr_off) >= next_start);
  assign hits_inc  = fwd_hits + 1'b1;

  assign count_zero = (count == '0);
  assign count_pos  = !count[sbnd_pkg::COUNT_W-1] && !count_zero;
  assign count_mag  = sbnd_pkg::FIELD_W'(-count);
  assign found_now  = fwd_take && !found && count_pos &&
                      (CMP_W'(hits_inc) == CMP_W'(count[sbnd_pkg::FIELD_W-1:0]));

  assign tag_end   = CNT_W'(rd_tag) + len_ext;
  assign walk_inc  = walk_hits + 1'b1;
  assign walk_take = rd_vld && rd_bit && (tag_end <= lim);

  assign win_ctrl.shift = byte_take;
  assign win_ctrl.len   = delim_len;

  sbnd_window #(
    .CELLS (MAX_DELIM_LEN)
  ) u_window (
    .clk     (clk),
    .ctrl    (win_ctrl),
    .byte_in (s_tdata),
    .delim   (delim_bytes),
    .hit     (win_hit)
  );

  always_comb begin
    cfg_count = signed'(cfg_data[sbnd_pkg::COUNT_W-1:0]);
    if (cfg_count > sbnd_pkg::COUNT_LIMIT) begin
      cfg_count = sbnd_pkg::COUNT_LIMIT;
    end else if (cfg_count < -sbnd_pkg::COUNT_LIMIT) begin
      cfg_count = -sbnd_pkg::COUNT_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && pos_ok) begin
      match_map[wr_off] <= win_hit;
    end
    rd_bit <= match_map[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      delim_bytes <= '0;
      delim_len   <= '0;
      count       <= '0;
      bytes_seen  <= '0;
      fwd_hits    <= '0;
      next_start  <= '0;
      found_off   <= '0;
      found       <= 1'b0;
      overflow    <= 1'b0;
      m_tvalid    <= 1'b0;
      rd_more     <= 1'b0;
      rd_vld      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sbnd_pkg::REG_DELIM_BYTES: delim_bytes <= cfg_data;
          sbnd_pkg::REG_DELIM_LEN: begin
            if (cfg_data[sbnd_pkg::DLEN_W-1:0] > sbnd_pkg::DLEN_W'(MAX_DELIM_LEN)) begin
              delim_len <= sbnd_pkg::DLEN_W'(MAX_DELIM_LEN);
            end else begin
              delim_len <= cfg_data[sbnd_pkg::DLEN_W-1:0];
            end
          end
          sbnd_pkg::REG_MATCH_COUNT: count <= cfg_count;
          default: ;
        endcase
      end

      if (m_tready && state != ST_SEND) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_RUN: begin
          if (byte_take) begin
            bytes_seen <= seen_inc;
          end
          if (in_fire && s_tuser && !byte_take) begin
            overflow <= 1'b1;
          end
          if (fwd_take) begin
            fwd_hits   <= hits_inc;
            next_start <= CNT_W'(wr_off) + len_ext;
          end
          if (found_now) begin
            found     <= 1'b1;
            found_off <= wr_off;
          end
          if (in_fire && s_tlast) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          res_start <= '0;
          rd_vld    <= 1'b0;
          if (count_zero || delim_len == '0) begin
            res_len <= '0;
            state   <= ST_SEND;
          end else if (count_pos) begin
            res_len <= found ? CNT_W'(found_off) : bytes_seen;
            state   <= ST_SEND;
          end else begin
            res_len <= bytes_seen;
            if (bytes_seen < len_ext) begin
              state <= ST_SEND;
            end else begin
              rd_addr   <= ADDR_W'(bytes_seen - len_ext);
              rd_more   <= 1'b1;
              lim       <= bytes_seen;
              walk_hits <= '0;
              state     <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          rd_vld <= rd_more;
          if (rd_more) begin
            rd_tag <= rd_addr;
            if (rd_addr == '0) begin
              rd_more <= 1'b0;
            end else begin
              rd_addr <= rd_addr - 1'b1;
            end
          end
          if (walk_take) begin
            walk_hits <= walk_inc;
            lim       <= CNT_W'(rd_tag);
          end
          priority if (walk_take && CMP_W'(walk_inc) == CMP_W'(count_mag)) begin
            res_start <= tag_end;
            res_len   <= bytes_seen - tag_end;
            state     <= ST_SEND;
          end else if (rd_vld && rd_tag == '0) begin
            state <= ST_SEND;
          end else begin
          end
        end
        ST_SEND: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= {(sbnd_pkg::OUT_DATA_W - 2 * sbnd_pkg::FIELD_W)'(0),
                           sbnd_pkg::FIELD_W'(res_len),
                           sbnd_pkg::FIELD_W'(res_start)};
            m_tuser    <= overflow;
            bytes_seen <= '0;
            fwd_hits   <= '0;
            next_start <= '0;
            found_off  <= '0;
            found      <= 1'b0;
            overflow   <= 1'b0;
            state      <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/sbnd_cell.sv @@
`default_nettype none

module sbnd_cell (
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] want,
  input  wire logic       active,
  output logic      [7:0] byte_q,
  output logic            eq
);

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_q <= byte_in;
    end
  end

  assign eq = !active || (byte_in == want);

endmodule

`default_nettype wire

@@ design/sbnd_window.sv @@
`default_nettype none

module sbnd_window #(
  parameter int CELLS = 8
) (
  input  wire logic                clk,
  input  wire sbnd_pkg::win_ctrl_t ctrl,
  input  wire logic [7:0]          byte_in,
  input  wire logic [63:0]         delim,
  output logic                     hit
);

  logic [7:0]       cell_q [CELLS];
  logic [CELLS-1:0] eq;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    logic [7:0] feed;
    logic [7:0] want;
    logic [2:0] idx;
    logic       active;

    if (k == 0) begin : g_head
      assign feed = byte_in;
    end else begin : g_link
      assign feed = cell_q[k-1];
    end

    // newest byte sits in cell 0, so cell k faces delimiter byte len-1-k
    assign active = ctrl.len > sbnd_pkg::DLEN_W'(k);
    assign idx    = 3'(ctrl.len - sbnd_pkg::DLEN_W'(k) - 4'd1);
    assign want   = delim[{idx, 3'b000} +: 8];

    sbnd_cell u_cell (
      .clk     (clk),
      .shift   (ctrl.shift),
      .byte_in (feed),
      .want    (want),
      .active  (active),
      .byte_q  (cell_q[k]),
      .eq      (eq[k])
    );
  end

  assign hit = &eq;

endmodule

`default_nettype wire

@@ design/sbnd_checker.sv @@
`default_nettype none

module sbnd_checker #(
  parameter int MAX_VALUE_LEN = 4096
) (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  s_tvalid,
  input wire logic                                  s_tready,
  input wire logic                                  s_tlast,
  input wire logic                                  m_tvalid,
  input wire logic                                  m_tready,
  input wire logic [sbnd_pkg::OUT_DATA_W-1:0]       m_tdata,
  input wire logic                                  m_tuser
);

  logic [sbnd_pkg::FIELD_W:0] slice_end;

  assign slice_end = {1'b0, m_tdata[sbnd_pkg::FIELD_W-1:0]} +
                     {1'b0, m_tdata[2*sbnd_pkg::FIELD_W-1:sbnd_pkg::FIELD_W]};

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_slice_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> slice_end <= (sbnd_pkg::FIELD_W + 1)'(MAX_VALUE_LEN))
    else $error("slice runs past the buffer");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken during result evaluation");

endmodule

bind substring_before_nth_delimiter sbnd_checker #(
  .MAX_VALUE_LEN (MAX_VALUE_LEN)
) u_sbnd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

@@ bench/slice_checker.sv @@
module slice_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [7:0]                       s_tdata,
  input  logic                             s_tuser,
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [sbnd_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic [sbnd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbnd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               outstanding,
  output int                               slices_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_CAP = 4096;
  localparam int DELIM_CAP = 8;
  localparam int FW        = sbnd_pkg::FIELD_W;
  localparam int ODW       = sbnd_pkg::OUT_DATA_W;

  typedef struct packed {
    logic [FW-1:0] start;
    logic [FW-1:0] length;
    logic          too_long;
  } slice_t;

  logic [63:0] delim;
  int          dlen;
  int          want;

  logic [63:0] window;
  bit          hit_map [VALUE_CAP];
  int          seen;
  int          hits;
  int          next_free;
  int          found_at;
  bit          found;
  bit          overflowed;

  slice_t      slice_q [$];

  function automatic bit window_hit();
    for (int j = 0; j < dlen; j++)
      if (delim[8*j +: 8] != window[8*(dlen-1-j) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic slice_t cut_slice();
    slice_t r;
    int     need;
    int     got;
    int     lim;
    r.start    = '0;
    r.length   = '0;
    r.too_long = overflowed;
    if (want == 0 || dlen == 0) return r;
    if (want > 0) begin
      r.length = found ? FW'(found_at) : FW'(seen);
    end else begin
      need = -want;
      got = 0;
      lim = seen;
      r.length = FW'(seen);
      if (seen >= dlen) begin
        for (int i = seen - dlen; i >= 0; i--) begin
          if (i + dlen <= lim && hit_map[i]) begin
            got++;
            if (got == need) begin
              r.start  = FW'(i + dlen);
              r.length = FW'(seen - (i + dlen));
              break;
            end
            lim = i;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic clear_value();
    window = '0;
    seen = 0;
    hits = 0;
    next_free = 0;
    found_at = 0;
    found = 1'b0;
    overflowed = 1'b0;
  endtask

  task automatic apply_reg(input logic [sbnd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sbnd_pkg::CFG_DATA_W-1:0] d);
    logic signed [sbnd_pkg::COUNT_W-1:0] c;
    c = d[sbnd_pkg::COUNT_W-1:0];
    case (idx)
      sbnd_pkg::REG_DELIM_BYTES: delim = d;
      sbnd_pkg::REG_DELIM_LEN: begin
        dlen = int'(d[sbnd_pkg::DLEN_W-1:0]);
        if (dlen > DELIM_CAP) dlen = DELIM_CAP;
      end
      sbnd_pkg::REG_MATCH_COUNT: begin
        want = int'(c);
        if (want > int'(sbnd_pkg::COUNT_LIMIT)) want = int'(sbnd_pkg::COUNT_LIMIT);
        if (want < -int'(sbnd_pkg::COUNT_LIMIT)) want = -int'(sbnd_pkg::COUNT_LIMIT);
      end
      default: ;
    endcase
  endtask

  task automatic take_item(input logic [7:0] b, input logic present, input logic lst);
    int o;
    bit hit;
    if (present) begin
      if (seen >= VALUE_CAP) begin
        overflowed = 1'b1;
      end else begin
        window = {window[55:0], b};
        seen++;
        if (dlen != 0 && seen >= dlen) begin
          o = seen - dlen;
          hit = window_hit();
          hit_map[o] = hit;
          if (hit && o >= next_free) begin
            hits++;
            next_free = o + dlen;
            if (!found && want > 0 && hits == want) begin
              found = 1'b1;
              found_at = o;
            end
          end
        end
      end
    end
    if (lst) begin
      slice_q.push_back(cut_slice());
      clear_value();
    end
  endtask

  task automatic check_result(input logic [ODW-1:0] d, input logic flag);
    slice_t e;
    if (slice_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual start %0d length %0d flag %0b",
               $time, d[FW-1:0], d[2*FW-1:FW], flag);
      mismatches++;
    end else begin
      e = slice_q.pop_front();
      slices_seen++;
      if (d[FW-1:0] != e.start) begin
        $display("%0t: result_start expected %0d actual %0d", $time, e.start, d[FW-1:0]);
        mismatches++;
      end
      if (d[2*FW-1:FW] != e.length) begin
        $display("%0t: slice_length expected %0d actual %0d", $time, e.length,
                 d[2*FW-1:FW]);
        mismatches++;
      end
      if (flag != e.too_long) begin
        $display("%0t: too_long expected %0b actual %0b", $time, e.too_long, flag);
        mismatches++;
      end
      if (d[ODW-1:2*FW] != '0) begin
        $display("%0t: tdata fill expected 0 actual %0h", $time, d[ODW-1:2*FW]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      delim = '0;
      dlen = 0;
      want = 0;
      clear_value();
      slice_q.delete();
      mismatches = 0;
      slices_seen = 0;
    end else begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) take_item(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) check_result(m_tdata, m_tuser);
    end
    outstanding <= slice_q.size();
  end

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [7:0]                       s_tdata = '0;   // value_byte
  logic                             s_tuser = 1'b0; // byte_present
  logic                             s_tlast = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [sbnd_pkg::OUT_DATA_W-1:0]  m_tdata;        // result_start, slice_length, zero fill
  logic                             m_tuser;        // too_long
  logic                             cfg_we = 1'b0;
  logic [sbnd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sbnd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int outstanding;
  int slices_seen;

  int cycles = 0;
  int transfers = 0;
  int settings = 0;
  bit steady = 1'b0;

  logic [7:0]  text_q [$];
  logic [7:0]  alphabet [4];
  logic [63:0] delim_word;
  int          delim_len;

  int count_pick [8] = '{4097, -8192, 1, -1, 8191, 0, -3, -4097};
  int len_pick [8]   = '{8, 15, 1, 2, 9, 3, 2, 0};

  substring_before_nth_delimiter u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  slice_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .slices_seen(slices_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) m_tready <= steady || ($urandom_range(99) >= 22);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic put_item(input logic [7:0] b, input logic present, input logic lst);
    while (!steady && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= present;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    transfers++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic poke_reg(input logic [sbnd_pkg::CFG_INDEX_W-1:0] idx,
                          input logic [sbnd_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits beyond each register are don't-care: randomize them
  task automatic set_config(input logic [63:0] bytes, input int len_w, input int count_w);
    settle();
    poke_reg(sbnd_pkg::REG_DELIM_BYTES, bytes);
    poke_reg(sbnd_pkg::REG_DELIM_LEN, {32'($urandom), 28'($urandom), 4'(len_w)});
    poke_reg(sbnd_pkg::REG_MATCH_COUNT, {32'($urandom), 18'($urandom), 14'(count_w)});
    delim_word = bytes;
    delim_len  = (len_w > 8) ? 8 : len_w;
    settings++;
  endtask

  task automatic load_string(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic build_value(input int n);
    text_q.delete();
    while (text_q.size() < n) begin
      if (delim_len != 0 && $urandom_range(99) < 25)
        for (int j = 0; j < delim_len; j++) text_q.push_back(delim_word[8*j +: 8]);
      else if ($urandom_range(99) < 85)
        text_q.push_back(alphabet[$urandom_range(3)]);
      else
        text_q.push_back(8'($urandom));
    end
    while (text_q.size() > n) void'(text_q.pop_back());
  endtask

  // marker_end closes the value with an extra transfer that carries no byte
  task automatic send_text(input int noise_pct, input bit marker_end);
    int last_i;
    last_i = text_q.size() - 1;
    foreach (text_q[i]) begin
      if ($urandom_range(99) < noise_pct) put_item(8'($urandom), 1'b0, 1'b0);
      put_item(text_q[i], 1'b1, i == last_i && !marker_end);
    end
    if (marker_end || text_q.size() == 0) put_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    logic [63:0] bytes;
    int          len_w;
    int          count_w;
    int          n;
    int          budget;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_string("ab");
    send_text(0, 1'b0);
    set_config(64'h2C, 1, 2);
    load_string("a,b,c");
    send_text(0, 1'b0);
    text_q.delete();
    send_text(0, 1'b0);
    put_item(8'hA5, 1'b0, 1'b0);
    load_string("x");
    send_text(0, 1'b0);
    set_config(64'h2C, 1, -2);
    load_string("a,b,c");
    send_text(0, 1'b0);
    set_config(64'hFFFF, 2, -1);
    text_q = '{8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_text(0, 1'b0);
    set_config(64'hFFFF, 2, 1);
    send_text(0, 1'b1);
    set_config(64'h6867_6665_6463_6261, 8, 1);
    load_string("ab");
    send_text(0, 1'b0);

    for (int ph = 0; ph < 16; ph++) begin
      foreach (alphabet[k]) alphabet[k] = 8'($urandom);
      if (ph < 8) begin
        len_w   = len_pick[ph];
        count_w = count_pick[ph];
      end else begin
        len_w   = $urandom_range(1, 8);
        count_w = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        if ($urandom_range(1) == 1) count_w = -count_w;
      end
      for (int j = 0; j < 8; j++)
        bytes[8*j +: 8] = (j < len_w) ? alphabet[$urandom_range(1)] : 8'($urandom);
      set_config(bytes, len_w, count_w);
      steady = (ph == 9 || ph == 10);
      budget = 0;
      while (budget < 92) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(24);
        build_value(n);
        send_text(4, $urandom_range(9) == 0);
        budget += n + 1;
      end
    end

    settle();
    repeat (50) @(posedge clk);
    $display("Checked %0d slices from %0d byte-channel transfers under %0d delimiter settings.",
             slices_seen, transfers, settings);
    $display("Covered empty and short values, saturated lengths and counts, both directions.");
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
